### src/i2c_bm_pkg.sv
// shared types, codes and phase tables for the i2c bit-level master
`default_nettype none

package i2c_bm_pkg;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  localparam logic [2:0] KIND_TICK = 3'd0;

  localparam logic [4:0] START_PHASES = 5'd3;
  localparam logic [4:0] STOP_PHASES  = 5'd3;
  localparam logic [4:0] WRITE_PHASES = 5'd27;
  localparam logic [4:0] READ_PHASES  = 5'd19;
  localparam logic [4:0] WRITE_ACK_SAMPLE = 5'd25;
  localparam logic [4:0] WRITE_DATA_END   = 5'd24;
  localparam logic [4:0] READ_DATA_END    = 5'd16;
  localparam logic [4:0] READ_ACK_HIGH    = 5'd17;
  localparam int unsigned TOP_BIT = 7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       cmd_rejected;
  } res_t;

  function automatic logic [4:0] phase_total(op_t op);
    logic [4:0] n;
    case (op)
      OP_START: n = START_PHASES;
      OP_STOP:  n = STOP_PHASES;
      OP_WRITE: n = WRITE_PHASES;
      OP_READ:  n = READ_PHASES;
      default:  n = 5'd0;
    endcase
    return n;
  endfunction

  // pin levels applied at the start of a phase, returned as {scl, sda}
  function automatic logic [1:0] enter_phase(op_t op, logic [4:0] p, logic [7:0] sb,
                                             logic ac, logic scl, logic sda);
    logic scl_o;
    logic sda_o;
    scl_o = scl;
    sda_o = sda;
    case (op)
      OP_START: begin
        if (p == 5'd0) begin
          scl_o = 1'b1;
          sda_o = 1'b1;
        end else if (p == 5'd1) begin
          sda_o = 1'b0;
        end else begin
          scl_o = 1'b0;
        end
      end
      OP_STOP: begin
        if (p == 5'd0) begin
          sda_o = 1'b0;
        end else if (p == 5'd1) begin
          scl_o = 1'b1;
        end else begin
          sda_o = 1'b1;
        end
      end
      OP_WRITE: begin
        if (p < WRITE_DATA_END) begin
          for (int i = 0; i <= TOP_BIT; i++) begin
            if (p == 5'(3 * i)) begin
              sda_o = sb[3'(TOP_BIT - i)];
            end else if (p == 5'(3 * i + 1)) begin
              scl_o = 1'b1;
            end else if (p == 5'(3 * i + 2)) begin
              scl_o = 1'b0;
            end
          end
        end else if (p == WRITE_DATA_END) begin
          sda_o = 1'b1;
        end else if (p == WRITE_ACK_SAMPLE) begin
          scl_o = 1'b1;
        end else begin
          scl_o = 1'b0;
        end
      end
      OP_READ: begin
        if (p < READ_DATA_END) begin
          if (p == 5'd0) begin
            sda_o = 1'b1;
          end
          scl_o = ~p[0];
        end else if (p == READ_DATA_END) begin
          sda_o = ~ac;
        end else if (p == READ_ACK_HIGH) begin
          scl_o = 1'b1;
        end else begin
          scl_o = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return {scl_o, sda_o};
  endfunction

endpackage

`default_nettype wire

### src/i2c_bm_core.sv
// bus operation sequencer: state registers and per-item next-state logic
`default_nettype none

module i2c_bm_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [15:0]         cfg_wr_data,
  input  wire logic                step_en,
  input  wire i2c_bm_pkg::item_t   item,
  output i2c_bm_pkg::res_t         res
);

  logic [15:0]     tpp_r;
  i2c_bm_pkg::op_t op_r, op_nxt;
  logic [4:0]      phase_r, phase_nxt;
  logic [15:0]     tc_r, tc_nxt;
  logic [7:0]      sb_r, sb_nxt;
  logic            ac_r, ac_nxt;
  logic            ackr_r, ackr_nxt;
  logic            scl_r, scl_nxt;
  logic            sda_r, sda_nxt;

  logic [15:0] len;
  logic [15:0] tc_inc;
  logic [4:0]  phase_inc;
  logic [1:0]  pins;
  logic        done;
  logic        rejected;
  logic [7:0]  rdata;
  logic        ackv;

  always_comb begin
    op_nxt    = op_r;
    phase_nxt = phase_r;
    tc_nxt    = tc_r;
    sb_nxt    = sb_r;
    ac_nxt    = ac_r;
    ackr_nxt  = ackr_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    done      = 1'b0;
    rejected  = 1'b0;
    rdata     = 8'd0;
    ackv      = 1'b0;
    pins      = {scl_r, sda_r};
    len       = (tpp_r == 16'd0) ? 16'd1 : tpp_r;
    tc_inc    = tc_r + 16'd1;
    phase_inc = phase_r + 5'd1;

    if (item.kind inside {[i2c_bm_pkg::OP_START : i2c_bm_pkg::OP_READ]}) begin
      if (op_r != i2c_bm_pkg::OP_IDLE) begin
        rejected = 1'b1;
      end else begin
        op_nxt    = i2c_bm_pkg::op_t'(item.kind);
        phase_nxt = 5'd0;
        tc_nxt    = 16'd0;
        if (item.kind == i2c_bm_pkg::OP_WRITE) begin
          sb_nxt = item.write_data;
        end
        if (item.kind == i2c_bm_pkg::OP_READ) begin
          sb_nxt = 8'd0;
          ac_nxt = item.send_ack;
        end
        pins    = i2c_bm_pkg::enter_phase(op_nxt, 5'd0, sb_nxt, ac_nxt, scl_r, sda_r);
        scl_nxt = pins[1];
        sda_nxt = pins[0];
      end
    end else if (item.kind == i2c_bm_pkg::KIND_TICK && op_r != i2c_bm_pkg::OP_IDLE) begin
      if (tc_inc >= len) begin
        tc_nxt = 16'd0;
        if (op_r == i2c_bm_pkg::OP_WRITE && phase_r == i2c_bm_pkg::WRITE_ACK_SAMPLE) begin
          ackr_nxt = ~item.sda_in;
        end
        if (op_r == i2c_bm_pkg::OP_READ && phase_r < i2c_bm_pkg::READ_DATA_END
            && !phase_r[0]) begin
          sb_nxt = {sb_r[6:0], item.sda_in};
        end
        if (phase_inc >= i2c_bm_pkg::phase_total(op_r)) begin
          done = 1'b1;
          if (op_r == i2c_bm_pkg::OP_READ) begin
            rdata   = sb_nxt;
            sda_nxt = 1'b1;
          end
          if (op_r == i2c_bm_pkg::OP_WRITE) begin
            ackv = ackr_nxt;
          end
          op_nxt    = i2c_bm_pkg::OP_IDLE;
          phase_nxt = 5'd0;
        end else begin
          phase_nxt = phase_inc;
          pins      = i2c_bm_pkg::enter_phase(op_r, phase_inc, sb_nxt, ac_r, scl_r, sda_r);
          scl_nxt   = pins[1];
          sda_nxt   = pins[0];
        end
      end else begin
        tc_nxt = tc_inc;
      end
    end

    res.scl_drive    = scl_nxt;
    res.sda_drive    = sda_nxt;
    res.busy_res     = (op_nxt != i2c_bm_pkg::OP_IDLE);
    res.done_res     = done;
    res.read_data    = rdata;
    res.ack_seen     = ackv;
    res.cmd_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpp_r   <= 16'd1;
      op_r    <= i2c_bm_pkg::OP_IDLE;
      phase_r <= 5'd0;
      tc_r    <= 16'd0;
      sb_r    <= 8'd0;
      ac_r    <= 1'b0;
      ackr_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        tpp_r <= cfg_wr_data;
      end
      if (step_en) begin
        op_r    <= op_nxt;
        phase_r <= phase_nxt;
        tc_r    <= tc_nxt;
        sb_r    <= sb_nxt;
        ac_r    <= ac_nxt;
        ackr_r  <= ackr_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
      end
    end
  end

  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    op_r != i2c_bm_pkg::OP_IDLE |-> phase_r < i2c_bm_pkg::phase_total(op_r))
    else $error("phase index past end of operation");

  a_idle_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    op_r == i2c_bm_pkg::OP_IDLE |-> phase_r == 5'd0)
    else $error("idle with nonzero phase");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.done_res |=> op_r == i2c_bm_pkg::OP_IDLE)
    else $error("operation still running after done");

  a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.cmd_rejected |-> op_r != i2c_bm_pkg::OP_IDLE && !res.done_res)
    else $error("command rejected while idle");

  a_tick_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !cfg_wr_en && item.kind == i2c_bm_pkg::KIND_TICK
    && op_r != i2c_bm_pkg::OP_IDLE && tpp_r != 16'd0
    |=> tc_r < tpp_r)
    else $error("tick count reached phase length");

endmodule

`default_nettype wire

### src/i2c_bit_level_master.sv
// top level: input register, sequencer core and result register
// an input item is held in the input register and its result in the result register
// one item per cycle if out_stall is low; each advances the sequencer at most one tick
// the stage registers pass stall straight through, so a full pipe holds two items
// reset (rst_n low, synchronous): idle, both lines released, ticks_per_phase back to 1
`default_nettype none

module i2c_bit_level_master (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_send_ack,
  input  wire logic        in_sda_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_scl_drive,
  output logic             out_sda_drive,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [7:0]       out_read_data,
  output logic             out_ack_seen,
  output logic             out_cmd_rejected
);

  logic              in_vld_r;
  i2c_bm_pkg::item_t in_item_r;
  logic              out_vld_r;
  i2c_bm_pkg::res_t  out_res_r;
  i2c_bm_pkg::res_t  step_res;
  logic              out_free;
  logic              fire;
  logic              in_xfer;

  assign out_free = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  i2c_bm_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (fire),
    .item        (in_item_r),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= '{kind: in_kind, write_data: in_write_data,
                     send_ack: in_send_ack, sda_in: in_sda_in};
    end
    if (fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_scl_drive    = out_res_r.scl_drive;
  assign out_sda_drive    = out_res_r.sda_drive;
  assign out_busy_res     = out_res_r.busy_res;
  assign out_done_res     = out_res_r.done_res;
  assign out_read_data    = out_res_r.read_data;
  assign out_ack_seen     = out_res_r.ack_seen;
  assign out_cmd_rejected = out_res_r.cmd_rejected;

endmodule

`default_nettype wire
